// ----- hdl/ksts_pkg.sv -----
// shared types and constants for the rank query over two sorted stores
`default_nettype none

package ksts_pkg;

  localparam int DEPTH_FIRST_DEF  = 1024;
  localparam int DEPTH_SECOND_DEF = 1024;

  localparam int FUNC_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int RANK_W      = 11;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR         = 2'd0,
    FUNC_APPEND_FIRST  = 2'd1,
    FUNC_APPEND_SECOND = 2'd2,
    FUNC_QUERY         = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic mid_rd;
    logic fin_rd;
    logic step;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic rank_bad;
    logic len_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/ksts_ctrl.sv -----
// controller state machine sequencing decode, search passes and result hand-off
`default_nettype none

module ksts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire ksts_pkg::sts_t sts_i,
  output ksts_pkg::cmd_t      cmd_o
);
  import ksts_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_READ   = 6'b000100,
    ST_STEP   = 6'b001000,
    ST_FINAL  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_query && !sts_i.rank_bad) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_READ: begin
        if (sts_i.len_zero) begin
          cmd_o.fin_rd = 1'b1;
          state_d      = ST_FINAL;
        end else begin
          cmd_o.mid_rd = 1'b1;
          state_d      = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_READ;
      end
      ST_FINAL: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ksts_dp.sv -----
// datapath: both stores, counts, search windows and the output register
`default_nettype none

module ksts_dp #(
  parameter int DEPTH_FIRST  = ksts_pkg::DEPTH_FIRST_DEF,
  parameter int DEPTH_SECOND = ksts_pkg::DEPTH_SECOND_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ksts_pkg::cmd_t                cmd_i,
  output ksts_pkg::sts_t                     sts_o,
  input  wire logic [ksts_pkg::IN_DATA_W-1:0]  in_data_i,
  input  wire logic [ksts_pkg::FUNC_W-1:0]     in_user_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ksts_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic [ksts_pkg::STATUS_W-1:0]      out_user_o
);
  import ksts_pkg::*;

  localparam int AW1 = (DEPTH_FIRST > 1) ? $clog2(DEPTH_FIRST) : 1;
  localparam int AW2 = (DEPTH_SECOND > 1) ? $clog2(DEPTH_SECOND) : 1;
  localparam int CW1 = $clog2(DEPTH_FIRST + 1);
  localparam int CW2 = $clog2(DEPTH_SECOND + 1);
  localparam int CWM = (CW1 > CW2) ? CW1 : CW2;
  localparam int EW  = ((CWM > RANK_W) ? CWM : RANK_W) + 1;

  logic [VALUE_W-1:0] mem1 [DEPTH_FIRST];
  logic [VALUE_W-1:0] mem2 [DEPTH_SECOND];
  logic [VALUE_W-1:0] rd1_q, rd2_q;

  func_e              func_q;
  logic [VALUE_W-1:0] value_q;
  logic [RANK_W-1:0]  rank_q, k_q, k_d;
  logic [CW1-1:0]     cnt1_q, cnt1_d, base1_q, base1_d, len1_q, len1_d;
  logic [CW2-1:0]     cnt2_q, cnt2_d, base2_q, base2_d, len2_q, len2_d;
  logic               a_second_q, a_second_d;
  logic [VALUE_W-1:0] res_value_q, res_value_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_data_q;
  status_e            out_status_q;

  logic               we1, we2;
  logic [EW-1:0]      base1_x, base2_x, len1_x, len2_x, k_x, rank_x;
  logic [EW-1:0]      addr1_x, addr2_x, la, lb, ha, hb, cut;
  logic               b_lt_a, swap, drop_b;

  always_comb begin
    base1_x = {{(EW-CW1){1'b0}}, base1_q};
    base2_x = {{(EW-CW2){1'b0}}, base2_q};
    len1_x  = {{(EW-CW1){1'b0}}, len1_q};
    len2_x  = {{(EW-CW2){1'b0}}, len2_q};
    k_x     = {{(EW-RANK_W){1'b0}}, k_q};
    rank_x  = {{(EW-RANK_W){1'b0}}, rank_q};
    if (cmd_i.fin_rd) begin
      addr1_x = base1_x + k_x;
      addr2_x = base2_x + k_x;
    end else begin
      addr1_x = base1_x + (len1_x >> 1);
      addr2_x = base2_x + (len2_x >> 1);
    end
    // the roles of the windows carry over from pass to pass
    b_lt_a = a_second_q ? ($signed(rd1_q) < $signed(rd2_q))
                        : ($signed(rd2_q) < $signed(rd1_q));
    swap   = a_second_q ^ b_lt_a;
    la     = swap ? len2_x : len1_x;
    lb     = swap ? len1_x : len2_x;
    ha     = la >> 1;
    hb     = lb >> 1;
    cut    = ha + EW'(1);
    drop_b = k_x < (ha + hb + EW'(1));
  end

  assign sts_o.is_query = (func_q == FUNC_QUERY);
  assign sts_o.rank_bad = rank_x >= ({{(EW-CW1){1'b0}}, cnt1_q} + {{(EW-CW2){1'b0}}, cnt2_q});
  assign sts_o.len_zero = (len1_q == '0) || (len2_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cnt1_d       = cnt1_q;
    cnt2_d       = cnt2_q;
    base1_d      = base1_q;
    base2_d      = base2_q;
    len1_d       = len1_q;
    len2_d       = len2_q;
    k_d          = k_q;
    a_second_d   = a_second_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    we1          = 1'b0;
    we2          = 1'b0;
    if (cmd_i.load) begin
      base1_d    = '0;
      base2_d    = '0;
      len1_d     = cnt1_q;
      len2_d     = cnt2_q;
      k_d        = in_data_i[VALUE_W +: RANK_W];
      a_second_d = 1'b0;
    end
    if (cmd_i.exec) begin
      res_value_d  = '0;
      res_status_d = STATUS_OK;
      case (func_q)
        FUNC_CLEAR: begin
          cnt1_d = '0;
          cnt2_d = '0;
        end
        FUNC_APPEND_FIRST: begin
          if (cnt1_q < CW1'(DEPTH_FIRST)) begin
            we1    = 1'b1;
            cnt1_d = cnt1_q + CW1'(1);
          end else begin
            res_status_d = STATUS_FULL;
          end
        end
        FUNC_APPEND_SECOND: begin
          if (cnt2_q < CW2'(DEPTH_SECOND)) begin
            we2    = 1'b1;
            cnt2_d = cnt2_q + CW2'(1);
          end else begin
            res_status_d = STATUS_FULL;
          end
        end
        default: begin
          res_status_d = STATUS_RANGE;
        end
      endcase
    end
    if (cmd_i.step) begin
      a_second_d = swap;
      if (drop_b) begin
        if (swap) begin
          len1_d = hb[CW1-1:0];
        end else begin
          len2_d = hb[CW2-1:0];
        end
      end else begin
        k_d = k_q - cut[RANK_W-1:0];
        if (swap) begin
          base2_d = base2_q + cut[CW2-1:0];
          len2_d  = len2_q - cut[CW2-1:0];
        end else begin
          base1_d = base1_q + cut[CW1-1:0];
          len1_d  = len1_q - cut[CW1-1:0];
        end
      end
    end
    if (cmd_i.fin) begin
      res_value_d  = (len1_q == '0) ? rd2_q : rd1_q;
      res_status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[cnt1_q[AW1-1:0]] <= value_q;
    end
    if (cmd_i.mid_rd || cmd_i.fin_rd) begin
      rd1_q <= mem1[addr1_x[AW1-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we2) begin
      mem2[cnt2_q[AW2-1:0]] <= value_q;
    end
    if (cmd_i.mid_rd || cmd_i.fin_rd) begin
      rd2_q <= mem2[addr2_x[AW2-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt1_q <= cnt1_d;
      cnt2_q <= cnt2_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_e'(in_user_i);
      value_q <= in_data_i[VALUE_W-1:0];
      rank_q  <= in_data_i[VALUE_W +: RANK_W];
    end
    base1_q      <= base1_d;
    base2_q      <= base2_d;
    len1_q       <= len1_d;
    len2_q       <= len2_d;
    k_q          <= k_d;
    a_second_q   <= a_second_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (cmd_i.emit) begin
      out_data_q   <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_status_q;

endmodule

`default_nettype wire

// ----- hdl/kth_smallest_of_two_sorted.sv -----
// top level: rank query over two sorted stores filled by append requests
// clear and append: the request is decoded and executed, then its result is registered once the output is free
// query: p search passes, p at most about log2(n1) + log2(n2) + 2
// each pass is one read of both store ports and one compare/update step
// one request in flight; the next is taken only after its result is registered
// reset clears both counts and the output valid flag; store contents and output data stay undefined
`default_nettype none

module kth_smallest_of_two_sorted #(
  parameter int DEPTH_FIRST  = ksts_pkg::DEPTH_FIRST_DEF,
  parameter int DEPTH_SECOND = ksts_pkg::DEPTH_SECOND_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [ksts_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // value[31:0], rank[42:32]
  input  wire logic [ksts_pkg::FUNC_W-1:0]      s_axis_tuser,  // func[1:0]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [ksts_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // value_out[31:0]
  output logic [ksts_pkg::STATUS_W-1:0]         m_axis_tuser   // status[1:0]
);
  import ksts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ksts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ksts_dp #(
    .DEPTH_FIRST  (DEPTH_FIRST),
    .DEPTH_SECOND (DEPTH_SECOND)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // one request at a time
  a_single_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while busy");

  // failed requests carry zero data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == '0))
    else $error("nonzero data on failed request");

  // result never emitted while still working on the next request
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit) |=> (m_axis_tvalid && s_axis_tready))
    else $error("result emit out of order");

endmodule

`default_nettype wire

// ----- tb/sv/kth_smallest_of_two_sorted_checker.sv -----
// checker that predicts rank query results and compares them with the result stream
`default_nettype none

module kth_smallest_of_two_sorted_checker #(
  parameter int DEPTH_FIRST  = ksts_pkg::DEPTH_FIRST_DEF,
  parameter int DEPTH_SECOND = ksts_pkg::DEPTH_SECOND_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            req_valid_i,
  input  wire logic                            req_ready_i,
  input  wire logic [ksts_pkg::IN_DATA_W-1:0]  req_data_i,   // value[31:0], rank[42:32]
  input  wire logic [ksts_pkg::FUNC_W-1:0]     req_user_i,   // func[1:0]
  input  wire logic                            res_valid_i,
  input  wire logic                            res_ready_i,
  input  wire logic [ksts_pkg::OUT_DATA_W-1:0] res_data_i,   // value_out[31:0]
  input  wire logic [ksts_pkg::STATUS_W-1:0]   res_user_i,   // status[1:0]
  output int unsigned                          mismatch_count_o,
  output int unsigned                          pending_count_o
);
  import ksts_pkg::*;

  localparam int AW1 = (DEPTH_FIRST > 1) ? $clog2(DEPTH_FIRST) : 1;
  localparam int AW2 = (DEPTH_SECOND > 1) ? $clog2(DEPTH_SECOND) : 1;

  typedef struct packed {
    func_e              func;
    logic [VALUE_W-1:0] value;
    status_e            status;
  } rank_result_t;

  typedef struct {
    bit          in_second;
    int unsigned base;
    int unsigned len;
  } span_t;

  logic [VALUE_W-1:0] first_mem  [DEPTH_FIRST];
  logic [VALUE_W-1:0] second_mem [DEPTH_SECOND];
  int unsigned        first_fill;
  int unsigned        second_fill;
  int unsigned        mismatches;
  rank_result_t       expected_results [$];

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [VALUE_W-1:0] span_at(span_t w, int unsigned off);
    int unsigned idx;
    idx = w.base + off;
    if (w.in_second) return (idx < DEPTH_SECOND) ? second_mem[idx[AW2-1:0]] : '0;
    return (idx < DEPTH_FIRST) ? first_mem[idx[AW1-1:0]] : '0;
  endfunction

  // window with the larger middle plays the upper side; on a tie the roles stay as they were
  function automatic logic [VALUE_W-1:0] merged_rank_value(int unsigned rank);
    span_t       lo_w;
    span_t       hi_w;
    span_t       swap_w;
    int unsigned k;
    int unsigned half_lo;
    int unsigned half_hi;
    lo_w = '{1'b0, 0, first_fill};
    hi_w = '{1'b1, 0, second_fill};
    k = rank;
    while (lo_w.len != 0 && hi_w.len != 0) begin
      half_lo = lo_w.len / 2;
      half_hi = hi_w.len / 2;
      if ($signed(span_at(hi_w, half_hi)) < $signed(span_at(lo_w, half_lo))) begin
        swap_w = lo_w;
        lo_w = hi_w;
        hi_w = swap_w;
        half_lo = lo_w.len / 2;
        half_hi = hi_w.len / 2;
      end
      if (k < half_lo + half_hi + 1) begin
        hi_w.len = half_hi;
      end else begin
        lo_w.base += half_lo + 1;
        lo_w.len -= half_lo + 1;
        k -= half_lo + 1;
      end
    end
    return (lo_w.len == 0) ? span_at(hi_w, k) : span_at(lo_w, k);
  endfunction

  function automatic rank_result_t predict_request(func_e func, logic [VALUE_W-1:0] value,
                                                   logic [RANK_W-1:0] rank);
    rank_result_t res;
    res.func = func;
    res.value = '0;
    res.status = STATUS_OK;
    case (func)
      FUNC_CLEAR: begin
        first_fill = 0;
        second_fill = 0;
      end
      FUNC_APPEND_FIRST: begin
        if (first_fill < DEPTH_FIRST) begin
          first_mem[first_fill[AW1-1:0]] = value;
          first_fill++;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      FUNC_APPEND_SECOND: begin
        if (second_fill < DEPTH_SECOND) begin
          second_mem[second_fill[AW2-1:0]] = value;
          second_fill++;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      FUNC_QUERY: begin
        if (rank >= first_fill + second_fill) res.status = STATUS_RANGE;
        else res.value = merged_rank_value(32'(rank));
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    rank_result_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        expected_results.push_back(predict_request(func_e'(req_user_i),
                                                   req_data_i[VALUE_W-1:0],
                                                   req_data_i[VALUE_W+RANK_W-1:VALUE_W]));
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: value %0d status %0d",
                                    $signed(res_data_i), res_user_i));
        end else begin
          want = expected_results.pop_front();
          if (res_data_i !== want.value) begin
            report_mismatch($sformatf("%s value got %0d expected %0d", want.func.name(),
                                      $signed(res_data_i), $signed(want.value)));
          end
          if (res_user_i !== want.status) begin
            report_mismatch($sformatf("%s status got %0d expected %s", want.func.name(),
                                      res_user_i, want.status.name()));
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o <= expected_results.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/kth_smallest_of_two_sorted_tb.sv -----
// testbench top: clock, reset and request/result stimulus for the rank query block
`default_nettype none

module kth_smallest_of_two_sorted_tb;
  import ksts_pkg::*;

  localparam int     RANDOM_ITEMS = 380;
  localparam int     QUIET_TAIL   = 100;
  localparam longint VALUE_MIN    = -64'sd2147483648;
  localparam longint VALUE_MAX    = 64'sd2147483647;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // value[31:0], rank[42:32]
  logic [FUNC_W-1:0]     s_axis_tuser = FUNC_CLEAR;   // func[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // value_out[31:0]
  logic [STATUS_W-1:0]   m_axis_tuser;   // status[1:0]

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned sent_count = 0;
  int unsigned rx_stall = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  kth_smallest_of_two_sorted i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  kth_smallest_of_two_sorted_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .req_user_i       (s_axis_tuser),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_user_i       (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      rx_stall <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [RANK_W-1:0] any_rank();
    return RANK_W'($urandom_range(0, 2047));
  endfunction

  task automatic send_req(func_e func, logic [VALUE_W-1:0] value, logic [RANK_W-1:0] rank);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W - RANK_W - VALUE_W){1'b0}}, rank, value};
    s_axis_tuser <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 3))
      0: return 2;
      1: return 1000;
      2: return 1 << 22;
      default: return 1 << 28;
    endcase
  endfunction

  function automatic longint pick_start();
    return ($urandom_range(0, 3) == 0) ? VALUE_MIN : longint'(int'($urandom));
  endfunction

  function automatic longint next_sorted(longint cur, int unsigned step_max);
    longint nxt;
    nxt = cur;
    if ($urandom_range(0, 3) != 0) nxt = cur + longint'($urandom_range(0, step_max));
    if (nxt > VALUE_MAX) nxt = VALUE_MAX;
    return nxt;
  endfunction

  // clear, fill both stores in ascending order with interleaved appends, then query
  task automatic run_sorted_set(int unsigned n1, int unsigned n2, int unsigned n_queries,
                                longint start1, longint start2, int unsigned step_max);
    longint            cur1;
    longint            cur2;
    int unsigned       left1;
    int unsigned       left2;
    int unsigned       total;
    logic [RANK_W-1:0] rank;
    cur1 = start1;
    cur2 = start2;
    left1 = n1;
    left2 = n2;
    total = ((n1 < DEPTH_FIRST_DEF) ? n1 : DEPTH_FIRST_DEF) +
            ((n2 < DEPTH_SECOND_DEF) ? n2 : DEPTH_SECOND_DEF);
    send_req(FUNC_CLEAR, $urandom, any_rank());
    while (left1 + left2 != 0) begin
      if (left2 == 0 || (left1 != 0 && $urandom_range(0, 1) == 1)) begin
        cur1 = next_sorted(cur1, step_max);
        send_req(FUNC_APPEND_FIRST, cur1[31:0], any_rank());
        left1--;
      end else begin
        cur2 = next_sorted(cur2, step_max);
        send_req(FUNC_APPEND_SECOND, cur2[31:0], any_rank());
        left2--;
      end
    end
    for (int unsigned i = 0; i < n_queries; i++) begin
      if (total != 0 && $urandom_range(0, 7) != 0) rank = RANK_W'($urandom_range(0, total - 1));
      else if (total < 2048 && $urandom_range(0, 1) == 1) rank = RANK_W'(total);
      else rank = any_rank();
      send_req(FUNC_QUERY, $urandom, rank);
    end
  endtask

  // unsorted appends, stray clears and queries on whatever the stores hold
  task automatic run_noise(int unsigned n);
    func_e func;
    repeat (n) begin
      func = ($urandom_range(0, 15) == 0) ? FUNC_CLEAR : func_e'($urandom_range(1, 3));
      send_req(func, $urandom,
               ($urandom_range(0, 1) == 1) ? RANK_W'($urandom_range(0, 31)) : any_rank());
    end
  endtask

  initial begin
    int unsigned random_base;
    int unsigned n1;
    int unsigned n2;
    longint      start1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stores, extremes, ties between the stores, ranks at both ends
    send_req(FUNC_QUERY, $urandom, 11'd0);
    send_req(FUNC_APPEND_FIRST, 32'h8000_0000, any_rank());
    send_req(FUNC_APPEND_FIRST, 32'hFFFF_FFFB, any_rank());
    send_req(FUNC_APPEND_FIRST, 32'h0000_0000, any_rank());
    send_req(FUNC_APPEND_FIRST, 32'h0000_0007, any_rank());
    send_req(FUNC_APPEND_FIRST, 32'h7FFF_FFFF, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'h8000_0000, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'hFFFF_FFFB, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'h0000_0003, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'h0000_0007, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'h7FFF_FFFF, any_rank());
    send_req(FUNC_QUERY, $urandom, 11'd0);
    send_req(FUNC_QUERY, $urandom, 11'd1);
    send_req(FUNC_QUERY, $urandom, 11'd4);
    send_req(FUNC_QUERY, $urandom, 11'd5);
    send_req(FUNC_QUERY, $urandom, 11'd9);
    send_req(FUNC_QUERY, $urandom, 11'd10);
    send_req(FUNC_QUERY, $urandom, 11'd2047);
    send_req(FUNC_CLEAR, $urandom, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'd11, any_rank());
    send_req(FUNC_APPEND_SECOND, 32'd22, any_rank());
    send_req(FUNC_QUERY, $urandom, 11'd1);
    send_req(FUNC_CLEAR, $urandom, any_rank());
    send_req(FUNC_APPEND_FIRST, 32'd9, any_rank());
    send_req(FUNC_QUERY, $urandom, 11'd0);
    send_req(FUNC_QUERY, $urandom, 11'd1);
    drain();

    // first store full plus dropped appends, ranks across the whole range
    run_sorted_set(DEPTH_FIRST_DEF + 2, 40, 30,
                   VALUE_MIN, VALUE_MIN + longint'($urandom_range(0, 1000)), 1 << 23);
    send_req(FUNC_QUERY, $urandom, 11'd0);
    send_req(FUNC_QUERY, $urandom, 11'd1023);
    send_req(FUNC_QUERY, $urandom, 11'd1063);
    send_req(FUNC_QUERY, $urandom, 11'd1064);

    random_base = sent_count;
    while (sent_count < random_base + RANDOM_ITEMS) begin
      if (sent_count >= random_base + RANDOM_ITEMS - QUIET_TAIL) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) < 7) begin
        n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
        n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
        start1 = pick_start();
        run_sorted_set(n1, n2, $urandom_range(2, 10), start1,
                       ($urandom_range(0, 2) == 0) ? start1 : pick_start(), pick_step());
      end else begin
        run_noise($urandom_range(3, 15));
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/ksts_pkg.sv
hdl/ksts_ctrl.sv
hdl/ksts_dp.sv
hdl/kth_smallest_of_two_sorted.sv
tb/sv/kth_smallest_of_two_sorted_checker.sv
tb/sv/kth_smallest_of_two_sorted_tb.sv
